// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- rtl/gbcb_pkg.sv -----
// ----------------------------------------------------------------------------
// gbcb_pkg
// shared constants and the command passed from front to back
// ----------------------------------------------------------------------------
package gbcb_pkg;

    localparam int COUNT_MAX_DEF = 1023;

    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_CLOSE = 8'h5d;
    localparam logic [7:0] CH_TOP   = 8'hff;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int CONSUMED_W = 10;

    // one command per classified byte
    typedef struct packed {
        logic                  init;     // restart the map
        logic                  neg;      // set is negated: marks clear bits
        logic                  rng_en;   // mark rng_lo..rng_hi
        logic [8:0]            rng_lo;
        logic [8:0]            rng_hi;
        logic                  dash_en;  // mark a literal dash
        logic                  fin_en;   // expression ends here
        logic                  closed;
        logic [CONSUMED_W-1:0] count;
    } cmd_t;

endpackage

// ----- rtl/gbcb_front.sv -----
// ----------------------------------------------------------------------------
// gbcb_front
// parses bracket bytes into init, mark and finish commands
// ----------------------------------------------------------------------------
module gbcb_front #(
    parameter int COUNT_MAX = gbcb_pkg::COUNT_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        pattern_byte,
    input  logic              start_req,
    output logic              q_push,
    output gbcb_pkg::cmd_t    q_cmd,
    input  logic              q_full
);

    localparam int CW = $clog2(COUNT_MAX + 1);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LEAD   = 4'b0010,
        PH_MEMBER = 4'b0100,
        PH_DASH   = 4'b1000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic [8:0]        prev_reg, prev_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     cnt_base, cnt_inc;
    logic [CW+9:0]     cnt_ext;
    logic              accept;
    logic              is_caret;
    logic              lead_path;
    logic              member_path;
    logic              dash_literal;
    logic [8:0]        byte_ext;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_caret = pattern_byte == gbcb_pkg::CH_CARET;
    assign byte_ext = {1'b0, pattern_byte};

    assign cnt_base = start_req ? '0 : count_reg;
    assign cnt_inc  = (cnt_base < CW'(COUNT_MAX)) ? cnt_base + CW'(1) : cnt_base;

    assign dash_literal = (pattern_byte == gbcb_pkg::CH_CLOSE) || (byte_ext < prev_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        prev_next   = prev_reg;
        count_next  = count_reg;
        q_cmd       = '0;
        q_push      = 1'b0;
        lead_path   = 1'b0;
        member_path = 1'b0;

        if (start_req)
        begin
            q_push     = 1'b1;
            q_cmd.init = 1'b1;
            neg_next   = is_caret;
            prev_next  = '0;
            count_next = '0;
            if (is_caret)
            begin
                count_next = cnt_inc;
                phase_next = PH_LEAD;
            end
            else
            begin
                lead_path = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    q_push    = 1'b1;
                    lead_path = 1'b1;
                end
                PH_MEMBER:
                begin
                    q_push      = 1'b1;
                    member_path = 1'b1;
                end
                PH_DASH:
                begin
                    q_push = 1'b1;
                    if (dash_literal)
                    begin
                        q_cmd.dash_en = 1'b1;
                        prev_next     = {1'b0, gbcb_pkg::CH_DASH};
                        member_path   = 1'b1;
                    end
                    else
                    begin
                        // range from the byte after the last mark
                        q_cmd.rng_en = 1'b1;
                        q_cmd.rng_lo = prev_reg + 9'd1;
                        q_cmd.rng_hi = (byte_ext > prev_reg) ? byte_ext : prev_reg + 9'd1;
                        prev_next    = (byte_ext > prev_reg) ? byte_ext : prev_reg + 9'd1;
                        count_next   = cnt_inc;
                        phase_next   = PH_MEMBER;
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end

        if (lead_path)
        begin
            if (pattern_byte == 8'd0)
            begin
                q_cmd.fin_en = 1'b1;
                phase_next   = PH_IDLE;
            end
            else
            begin
                q_cmd.rng_en = 1'b1;
                q_cmd.rng_lo = byte_ext;
                q_cmd.rng_hi = byte_ext;
                prev_next    = byte_ext;
                count_next   = cnt_inc;
                phase_next   = PH_MEMBER;
            end
        end

        if (member_path)
        begin
            if (pattern_byte == gbcb_pkg::CH_DASH)
            begin
                count_next = cnt_inc;
                phase_next = PH_DASH;
            end
            else if (pattern_byte == gbcb_pkg::CH_CLOSE)
            begin
                count_next   = cnt_inc;
                q_cmd.fin_en = 1'b1;
                q_cmd.closed = 1'b1;
                phase_next   = PH_IDLE;
            end
            else if (pattern_byte == 8'd0)
            begin
                q_cmd.fin_en = 1'b1;
                phase_next   = PH_IDLE;
            end
            else
            begin
                q_cmd.rng_en = 1'b1;
                q_cmd.rng_lo = byte_ext;
                q_cmd.rng_hi = byte_ext;
                prev_next    = byte_ext;
                count_next   = cnt_inc;
                phase_next   = PH_MEMBER;
            end
        end

        q_cmd.neg   = neg_next;
        cnt_ext     = {{gbcb_pkg::CONSUMED_W{1'b0}}, count_next};
        q_cmd.count = cnt_ext[gbcb_pkg::CONSUMED_W-1:0];
        q_push      = q_push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            neg_reg   <= 1'b0;
            prev_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/gbcb_queue.sv -----
// ----------------------------------------------------------------------------
// gbcb_queue
// two-entry command queue between parser and map builder
// ----------------------------------------------------------------------------
module gbcb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gbcb_pkg::cmd_t    push_cmd,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop_ready,
    output gbcb_pkg::cmd_t    pop_cmd
);

    gbcb_pkg::cmd_t                   mem [gbcb_pkg::QUEUE_DEPTH];
    logic [gbcb_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [gbcb_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [gbcb_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                             pop;

    assign full      = cnt_reg == gbcb_pkg::QCNT_W'(gbcb_pkg::QUEUE_DEPTH);
    assign pop_valid = cnt_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/gbcb_back.sv -----
// ----------------------------------------------------------------------------
// gbcb_back
// applies commands to the 256-bit map and streams out four map words
// ----------------------------------------------------------------------------
module gbcb_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  gbcb_pkg::cmd_t                    q_cmd,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [63:0]                       map_word,
    output logic [1:0]                        word_index,
    output logic                              last,
    output logic [gbcb_pkg::CONSUMED_W-1:0]   consumed,
    output logic                              closed
);

    logic [255:0]                     map_reg, map_next;
    logic [255:0]                     map_base;
    logic [255:0]                     mark_mask;
    logic [63:0]                      word_reg [4];
    logic [1:0]                       idx_reg, idx_next;
    logic                             busy_reg, busy_next;
    logic [gbcb_pkg::CONSUMED_W-1:0]  consumed_reg;
    logic                             closed_reg;
    logic                             pop;
    logic                             out_take;
    logic                             snap;

    assign out_take = busy_reg && out_ready;
    // a finish waits until the previous burst has handed over its last word
    assign q_ready  = !q_cmd.fin_en || !busy_reg || (out_take && idx_reg == 2'd3);
    assign pop      = q_valid && q_ready;
    assign snap     = pop && q_cmd.fin_en;

    always_comb
    begin
        for (int i = 0; i <= int'(gbcb_pkg::CH_TOP); i++)
        begin
            mark_mask[i] = (q_cmd.rng_en && (9'(i) >= q_cmd.rng_lo)
                            && (9'(i) <= q_cmd.rng_hi))
                         || (q_cmd.dash_en && (8'(i) == gbcb_pkg::CH_DASH));
        end
        map_base = q_cmd.init ? {256{q_cmd.neg}} : map_reg;
        map_next = q_cmd.neg ? (map_base & ~mark_mask) : (map_base | mark_mask);
    end

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (out_take)
        begin
            idx_next = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end
        if (snap)
        begin
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg  <= '0;
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                map_reg <= map_next;
            end
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            for (int w = 0; w < 4; w++)
            begin
                word_reg[w] <= map_next[w*64 +: 64];
            end
            consumed_reg <= q_cmd.count;
            closed_reg   <= q_cmd.closed;
        end
    end

    assign out_valid  = busy_reg;
    assign map_word   = word_reg[idx_reg];
    assign word_index = idx_reg;
    assign last       = idx_reg == 2'd3;
    assign consumed   = consumed_reg;
    assign closed     = closed_reg;

endmodule

// ----- rtl/glob_bracket_class_builder.sv -----
// ----------------------------------------------------------------------------
// glob_bracket_class_builder
// streams a glob bracket expression in and its 256-bit membership map out
// ----------------------------------------------------------------------------
// input channel: one pattern byte per transaction, start_req on the first byte
// of each expression. a caret first negates the set; ranges, literal dashes,
// a closing bracket (counted) or a nul (not counted) are handled as in fnmatch.
// bytes outside an expression are accepted and dropped.
// output channel: four transactions per expression, word_index 0..3, last on
// the fourth, with the byte count and closed flag repeated on each word.
// throughput: one byte per cycle while the queue is not full; the map is
// updated by a 256-wide parallel compare in the back end. the front end keeps
// parsing while the back end drains, through a two-entry command queue.
// the ending byte's command is written into the queue, then popped into the
// word registers; the four words then leave at one per cycle while out_ready
// is high. a stalled receiver holds the current word; a new ending byte then
// waits in the queue and, once the queue is full, in_ready drops.
// reset clears the parser, the queue and the map; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glob_bracket_class_builder #(
    parameter int COUNT_MAX = gbcb_pkg::COUNT_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        pattern_byte,
    input  logic                              start_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [63:0]                       map_word,
    output logic [1:0]                        word_index,
    output logic                              last,
    output logic [gbcb_pkg::CONSUMED_W-1:0]   consumed,
    output logic                              closed
);

    logic              q_push;
    logic              q_full;
    logic              q_valid;
    logic              q_ready;
    gbcb_pkg::cmd_t    push_cmd;
    gbcb_pkg::cmd_t    pop_cmd;

    gbcb_front #(
        .COUNT_MAX (COUNT_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pattern_byte (pattern_byte),
        .start_req    (start_req),
        .q_push       (q_push),
        .q_cmd        (push_cmd),
        .q_full       (q_full)
    );

    gbcb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_cmd   (pop_cmd)
    );

    gbcb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .map_word   (map_word),
        .word_index (word_index),
        .last       (last),
        .consumed   (consumed),
        .closed     (closed)
    );

    // a burst never breaks up once a word has been taken
    `ASSERT_AT(a_burst_continues, clk, rst_n, out_valid && out_ready && !last |=> out_valid)

    // words leave in order
    `ASSERT_AT(a_word_order, clk, rst_n, out_valid && out_ready && !last |=> word_index == $past(word_index) + 2'd1)

    // count and closed flag hold across a whole burst
    `ASSERT_AT(a_burst_stable, clk, rst_n, out_valid && !(out_ready && last) |=> $stable(consumed) && $stable(closed))

    // the parser never writes into a full queue
    `ASSERT_NEVER(a_no_overflow, clk, rst_n, q_push && q_full)

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the bracket expression map builder against a cycle-free predictor
// ----------------------------------------------------------------------------
// pattern bytes go in through a random-gap sender, map words come out through
// a random-stall receiver. every accepted byte runs through a local parser
// that queues the four expected map words of an ending expression. a checker
// compares each output transaction with the oldest queued word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COUNT_LIMIT = gbcb_pkg::COUNT_MAX_DEF;
    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_CYCLES = 200;

    typedef enum logic [3:0] {
        ST_IDLE        = 4'b0001,
        ST_AFTER_CARET = 4'b0010,
        ST_MEMBER      = 4'b0100,
        ST_RANGE       = 4'b1000
    } parse_state_t;

    typedef struct {
        logic [63:0]                     word;
        logic [1:0]                      idx;
        logic                            lst;
        logic [gbcb_pkg::CONSUMED_W-1:0] cnt;
        logic                            cls;
    } map_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      pattern_byte = 8'h00;
    logic                            start_req = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [63:0]                     map_word;
    logic [1:0]                      word_index;
    logic                            last;
    logic [gbcb_pkg::CONSUMED_W-1:0] consumed;
    logic                            closed;

    // parser copy
    logic [63:0]                     set_bits [4];
    logic                            set_negated;
    logic [8:0]                      prev_char;
    parse_state_t                    parse_state = ST_IDLE;
    logic [gbcb_pkg::CONSUMED_W-1:0] bytes_taken;
    logic                            expr_done;
    logic                            expr_closed;

    map_word_t map_words_due [$];
    int        err_count = 0;
    int        counted_bytes = 0;
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;
    bit        hold_req = 1'b0;

    glob_bracket_class_builder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pattern_byte (pattern_byte),
        .start_req    (start_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .map_word     (map_word),
        .word_index   (word_index),
        .last         (last),
        .consumed     (consumed),
        .closed       (closed)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void bump_count();
        if (bytes_taken < COUNT_LIMIT)
            bytes_taken++;
    endfunction

    // a character above the top byte is silently dropped
    function automatic void mark_char(int c);
        if (c > gbcb_pkg::CH_TOP)
            return;
        set_bits[c >> 6][c & 63] = !set_negated;
    endfunction

    function automatic void take_member(logic [7:0] b);
        if (b == gbcb_pkg::CH_DASH)
        begin
            bump_count();
            parse_state = ST_RANGE;
        end
        else if (b == gbcb_pkg::CH_CLOSE)
        begin
            bump_count();
            expr_done = 1'b1;
            expr_closed = 1'b1;
            parse_state = ST_IDLE;
        end
        else if (b == 8'h00)
        begin
            expr_done = 1'b1;
            expr_closed = 1'b0;
            parse_state = ST_IDLE;
        end
        else
        begin
            mark_char(b);
            prev_char = {1'b0, b};
            bump_count();
            parse_state = ST_MEMBER;
        end
    endfunction

    function automatic void take_lead(logic [7:0] b);
        if (b == 8'h00)
        begin
            expr_done = 1'b1;
            expr_closed = 1'b0;
            parse_state = ST_IDLE;
            return;
        end
        mark_char(b);
        prev_char = {1'b0, b};
        bump_count();
        parse_state = ST_MEMBER;
    endfunction

    function automatic void take_range_end(logic [7:0] n);
        int c;
        if (n == gbcb_pkg::CH_CLOSE || {1'b0, n} < prev_char)
        begin
            // dash was literal after all
            mark_char(gbcb_pkg::CH_DASH);
            prev_char = {1'b0, gbcb_pkg::CH_DASH};
            parse_state = ST_MEMBER;
            take_member(n);
            return;
        end
        bump_count();
        c = prev_char;
        do
        begin
            c++;
            mark_char(c);
        end
        while (c < n);
        prev_char = ({1'b0, n} > prev_char) ? {1'b0, n} : prev_char + 9'd1;
        parse_state = ST_MEMBER;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic s);
        map_word_t w;
        expr_done = 1'b0;
        if (s)
        begin
            set_negated = (b == gbcb_pkg::CH_CARET);
            for (int k = 0; k < 4; k++)
                set_bits[k] = set_negated ? '1 : '0;
            prev_char = '0;
            bytes_taken = '0;
            if (set_negated)
            begin
                bump_count();
                parse_state = ST_AFTER_CARET;
            end
            else
                take_lead(b);
        end
        else
        begin
            case (parse_state)
                ST_AFTER_CARET: take_lead(b);
                ST_MEMBER:      take_member(b);
                ST_RANGE:       take_range_end(b);
                default:        ;
            endcase
        end
        if (expr_done)
        begin
            for (int k = 0; k < 4; k++)
            begin
                w.word = set_bits[k];
                w.idx = k[1:0];
                w.lst = (k == 3);
                w.cnt = bytes_taken;
                w.cls = expr_closed;
                map_words_due.push_back(w);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pattern_byte <= b;
        start_req <= s;
        do
            @(posedge clk);
        while (!in_ready);
        if (s || parse_state != ST_IDLE)
            counted_bytes++;
        parse_byte(b, s);
    endtask

    always @(posedge clk)
    begin
        map_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (map_words_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected map word %0d: %h", word_index, map_word);
            end
            else
            begin
                w = map_words_due.pop_front();
                if (map_word !== w.word || word_index !== w.idx || last !== w.lst
                    || consumed !== w.cnt || closed !== w.cls)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: exp %h/%0d/%0d/%0d/%0d got %h/%0d/%0d/%0d/%0d",
                                 w.word, w.idx, w.lst, w.cnt, w.cls,
                                 map_word, word_index, last, consumed, closed);
                end
            end
        end
    end

    // receiver: random stall per transaction, long hold on request
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 16);
            if (hold_req)
            begin
                gap += HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    function automatic logic [7:0] pick_member();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == gbcb_pkg::CH_CLOSE || b == gbcb_pkg::CH_DASH);
        return b;
    endfunction

    task automatic test_empty_sets();
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(gbcb_pkg::CH_CARET, 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_ranges();
        send_byte("a", 1'b1);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte("c", 1'b0);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte("e", 1'b0);
        send_byte(gbcb_pkg::CH_CLOSE, 1'b0);
        // equal ends mark one past the end
        send_byte(gbcb_pkg::CH_CARET, 1'b1);
        send_byte("x", 1'b0);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte("x", 1'b0);
        send_byte(gbcb_pkg::CH_CLOSE, 1'b0);
    endtask

    task automatic test_literal_dashes();
        // close bracket first is literal, reversed range keeps the dash
        send_byte(gbcb_pkg::CH_CLOSE, 1'b1);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte("A", 1'b0);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte(gbcb_pkg::CH_CLOSE, 1'b0);
    endtask

    task automatic test_top_of_range();
        send_byte(8'hff, 1'b1);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_restart();
        send_byte("k", 1'b1);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte("q", 1'b1);
        send_byte(gbcb_pkg::CH_DASH, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // receiver stops while short expressions keep coming in back to back
    task automatic test_stalled_receiver();
        tx_steady = 1'b1;
        hold_req = 1'b1;
        repeat (8)
        begin
            send_byte(pick_member(), 1'b1);
            send_byte(gbcb_pkg::CH_CLOSE, 1'b0);
        end
        tx_steady = 1'b0;
    endtask

    task automatic send_expression();
        logic [7:0] lo;
        int         hi;
        logic       first;
        first = 1'b1;
        if ($urandom_range(0, 3) == 0)
        begin
            send_byte(gbcb_pkg::CH_CARET, 1'b1);
            first = 1'b0;
        end
        case ($urandom_range(0, 19))
            0:       send_byte(8'h00, first);
            1:       send_byte(gbcb_pkg::CH_CLOSE, first);
            2:       send_byte(gbcb_pkg::CH_DASH, first);
            default: send_byte(pick_member(), first);
        endcase
        if (parse_state == ST_IDLE)
            return;
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 5))
                0: send_byte(pick_member(), 1'b0);
                1:
                begin
                    lo = pick_member();
                    hi = ($urandom_range(0, 3) == 0) ? $urandom_range(lo, 255)
                                                     : lo + $urandom_range(0, 30);
                    if (hi > 255)
                        hi = 255;
                    send_byte(lo, 1'b0);
                    send_byte(gbcb_pkg::CH_DASH, 1'b0);
                    send_byte(hi[7:0], 1'b0);
                end
                2:
                begin
                    lo = pick_member();
                    send_byte(lo, 1'b0);
                    send_byte(gbcb_pkg::CH_DASH, 1'b0);
                    send_byte(lo, 1'b0);
                end
                3:
                begin
                    do
                        lo = pick_member();
                    while (lo < 8'h02);
                    hi = $urandom_range(1, lo - 1);
                    if (hi == gbcb_pkg::CH_CLOSE)
                        hi--;
                    send_byte(lo, 1'b0);
                    send_byte(gbcb_pkg::CH_DASH, 1'b0);
                    send_byte(hi[7:0], 1'b0);
                end
                4:
                begin
                    send_byte(gbcb_pkg::CH_DASH, 1'b0);
                    send_byte(pick_member(), 1'b0);
                end
                default:
                begin
                    // abandon; the next start byte restarts the parse
                    if ($urandom_range(0, 3) == 0)
                        return;
                    send_byte(pick_member(), 1'b0);
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            send_byte(gbcb_pkg::CH_DASH, 1'b0);
        if ($urandom_range(0, 4) == 0)
            send_byte(8'h00, 1'b0);
        else
            send_byte(gbcb_pkg::CH_CLOSE, 1'b0);
    endtask

    task automatic test_random_expressions();
        counted_bytes = 0;
        while (counted_bytes < RANDOM_ITEMS)
        begin
            tx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            else
                send_expression();
            if ($urandom_range(0, 5) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_sets();
        test_ranges();
        test_literal_dashes();
        test_top_of_range();
        test_restart();
        test_stalled_receiver();
        test_random_expressions();
        in_valid <= 1'b0;
        while (map_words_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
